[hdl/assert_macros.svh]
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on clk, ignored while rst_n is low
`define MVT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property sampled on clk, also checked while rst_n is low
`define MVT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mvt_pkg.sv]
// Package: shared constants and types of the 4x4 matrix-vector transform
`timescale 1ns / 1ps

package mvt_pkg;

    localparam int FIELD_W       = 32;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int DIM           = 4;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORD_WIDTH_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COL0_ROWS01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL0_ROWS23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL1_ROWS01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL1_ROWS23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COL2_ROWS01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COL2_ROWS23 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COL3_ROWS01 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COL3_ROWS23 = 3'd7;

    typedef struct packed {
        logic load_sum;
        logic load_sat;
    } merge_ctrl_t;

endpackage

[hdl/mvt_lane.sv]
// Column lane: multiplies one vector element by the four elements of its column
`timescale 1ns / 1ps

module mvt_lane #(
    parameter int WORD_WIDTH = mvt_pkg::WORD_WIDTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        load,
    input  logic signed [WORD_WIDTH-1:0]                v,
    input  logic [mvt_pkg::DIM-1:0][WORD_WIDTH-1:0]     col,
    output logic [mvt_pkg::DIM-1:0][2*WORD_WIDTH-1:0]   prod
);

    logic [mvt_pkg::DIM-1:0][2*WORD_WIDTH-1:0] prod_reg;
    logic [mvt_pkg::DIM-1:0][2*WORD_WIDTH-1:0] prod_next;

    always_comb
    begin
        for (int r = 0; r < mvt_pkg::DIM; r++)
        begin
            prod_next[r] = $signed(col[r]) * v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[hdl/mvt_merge.sv]
// Merge stage: sums the lane products per row, then floors and saturates
`timescale 1ns / 1ps

module mvt_merge #(
    parameter int WORD_WIDTH = mvt_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
    input  logic                                                        clk,
    input  mvt_pkg::merge_ctrl_t                                        ctrl,
    input  logic [mvt_pkg::DIM-1:0][mvt_pkg::DIM-1:0][2*WORD_WIDTH-1:0] lane_prod,
    output logic [mvt_pkg::DIM-1:0][mvt_pkg::FIELD_W-1:0]               rows
);

    localparam int PROD_W = 2 * WORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] MAX_W =
        {{(SUM_W - WORD_WIDTH + 1){1'b0}}, {(WORD_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] MIN_W =
        {{(SUM_W - WORD_WIDTH + 1){1'b1}}, {(WORD_WIDTH - 1){1'b0}}};

    logic [mvt_pkg::DIM-1:0][SUM_W-1:0]            sum_reg;
    logic [mvt_pkg::DIM-1:0][SUM_W-1:0]            sum_next;
    logic [mvt_pkg::DIM-1:0][mvt_pkg::FIELD_W-1:0] row_reg;
    logic [mvt_pkg::DIM-1:0][mvt_pkg::FIELD_W-1:0] row_next;

    always_comb
    begin
        for (int r = 0; r < mvt_pkg::DIM; r++)
        begin
            sum_next[r] = SUM_W'($signed(lane_prod[0][r])) + SUM_W'($signed(lane_prod[1][r]))
                        + SUM_W'($signed(lane_prod[2][r])) + SUM_W'($signed(lane_prod[3][r]));
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0]      sh;
        logic signed [WORD_WIDTH-1:0] sat;
        for (int r = 0; r < mvt_pkg::DIM; r++)
        begin
            sh = $signed(sum_reg[r]) >>> FRAC_BITS;
            if (sh > MAX_W)
            begin
                sat = MAX_W[WORD_WIDTH-1:0];
            end
            else if (sh < MIN_W)
            begin
                sat = MIN_W[WORD_WIDTH-1:0];
            end
            else
            begin
                sat = sh[WORD_WIDTH-1:0];
            end
            row_next[r] = mvt_pkg::FIELD_W'(sat);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_sum)
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.load_sat)
        begin
            row_reg <= row_next;
        end
    end

    assign rows = row_reg;

endmodule

[hdl/matrix_vector_transform_4x4.sv]
// Top level: 4x4 fixed-point matrix-vector transform with four column lanes
// Four column lanes of four multipliers each feed a summing stage and a
// floor-and-saturate stage, whose registers an item passes to reach rx..rw.
// Throughput: one item per cycle unless out_ready stalls the output.
// Reset clears all valid flags and loads the identity matrix.
`timescale 1ns / 1ps

module matrix_vector_transform_4x4 #(
    parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF,
    parameter int WORD_WIDTH = mvt_pkg::WORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mvt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mvt_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [mvt_pkg::FIELD_W-1:0]  vx,
    input  logic signed [mvt_pkg::FIELD_W-1:0]  vy,
    input  logic signed [mvt_pkg::FIELD_W-1:0]  vz,
    input  logic signed [mvt_pkg::FIELD_W-1:0]  vw,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mvt_pkg::FIELD_W-1:0]  rx,
    output logic signed [mvt_pkg::FIELD_W-1:0]  ry,
    output logic signed [mvt_pkg::FIELD_W-1:0]  rz,
    output logic signed [mvt_pkg::FIELD_W-1:0]  rw
);

    localparam int NUM_CFG = 2 * mvt_pkg::DIM;
    localparam logic [mvt_pkg::CFG_W-1:0] ONE_LO = mvt_pkg::CFG_W'(1) << FRAC_BITS;
    localparam logic [mvt_pkg::CFG_W-1:0] ONE_HI = ONE_LO << mvt_pkg::FIELD_W;

    logic [mvt_pkg::CFG_W-1:0] cfg_reg [NUM_CFG];

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic adv_s1;
    logic adv_s2;
    logic adv_out;

    logic [mvt_pkg::DIM-1:0][WORD_WIDTH-1:0]                     vec;
    logic [mvt_pkg::DIM-1:0][mvt_pkg::DIM-1:0][WORD_WIDTH-1:0]   cols;
    logic [mvt_pkg::DIM-1:0][mvt_pkg::DIM-1:0][2*WORD_WIDTH-1:0] lane_prod;
    logic [mvt_pkg::DIM-1:0][mvt_pkg::FIELD_W-1:0]               rows;
    mvt_pkg::merge_ctrl_t                                        merge_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[mvt_pkg::CFG_COL0_ROWS01] <= ONE_LO;
            cfg_reg[mvt_pkg::CFG_COL0_ROWS23] <= '0;
            cfg_reg[mvt_pkg::CFG_COL1_ROWS01] <= ONE_HI;
            cfg_reg[mvt_pkg::CFG_COL1_ROWS23] <= '0;
            cfg_reg[mvt_pkg::CFG_COL2_ROWS01] <= '0;
            cfg_reg[mvt_pkg::CFG_COL2_ROWS23] <= ONE_LO;
            cfg_reg[mvt_pkg::CFG_COL3_ROWS01] <= '0;
            cfg_reg[mvt_pkg::CFG_COL3_ROWS23] <= ONE_HI;
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // pick each element from the low bits of its 32-bit half
    always_comb
    begin
        for (int c = 0; c < mvt_pkg::DIM; c++)
        begin
            for (int r = 0; r < mvt_pkg::DIM; r++)
            begin
                cols[c][r] = cfg_reg[2 * c + r / 2][mvt_pkg::FIELD_W * (r % 2) +: WORD_WIDTH];
            end
        end
    end

    assign vec[0] = vx[WORD_WIDTH-1:0];
    assign vec[1] = vy[WORD_WIDTH-1:0];
    assign vec[2] = vz[WORD_WIDTH-1:0];
    assign vec[3] = vw[WORD_WIDTH-1:0];

    // advance a stage when it is empty or its item moves on
    assign adv_out  = !out_valid_reg || out_ready;
    assign adv_s2   = !s2_valid_reg || adv_out;
    assign adv_s1   = !s1_valid_reg || adv_s2;
    assign in_ready = adv_s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    genvar gc;
    generate
        for (gc = 0; gc < mvt_pkg::DIM; gc++)
        begin : g_lane
            mvt_lane #(
                .WORD_WIDTH (WORD_WIDTH)
            ) u_lane (
                .clk  (clk),
                .load (adv_s1 && in_valid),
                .v    ($signed(vec[gc])),
                .col  (cols[gc]),
                .prod (lane_prod[gc])
            );
        end
    endgenerate

    assign merge_ctrl.load_sum = adv_s2 && s1_valid_reg;
    assign merge_ctrl.load_sat = adv_out && s2_valid_reg;

    mvt_merge #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_merge (
        .clk       (clk),
        .ctrl      (merge_ctrl),
        .lane_prod (lane_prod),
        .rows      (rows)
    );

    assign out_valid = out_valid_reg;
    assign rx        = $signed(rows[0]);
    assign ry        = $signed(rows[1]);
    assign rz        = $signed(rows[2]);
    assign rw        = $signed(rows[3]);

endmodule

[hdl/mvt_checker.sv]
// Port checker for the matrix-vector transform, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvt_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [mvt_pkg::FIELD_W-1:0] rx,
    input logic signed [mvt_pkg::FIELD_W-1:0] ry,
    input logic signed [mvt_pkg::FIELD_W-1:0] rz,
    input logic signed [mvt_pkg::FIELD_W-1:0] rw
);

    logic [2:0] count_reg;
    logic [2:0] count_next;

    // track items accepted but not yet delivered
    always_comb
    begin
        count_next = count_reg;
        if (in_valid && in_ready && !(out_valid && out_ready))
        begin
            count_next = count_reg + 3'd1;
        end
        else if (!(in_valid && in_ready) && out_valid && out_ready)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `MVT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(rx) && $stable(ry) && $stable(rz) && $stable(rw), "result changed while stalled")
    `MVT_ASSERT(a_no_invented, out_valid |-> count_reg != 3'd0, "result without an accepted item")
    `MVT_ASSERT(a_depth, count_reg <= 3'd3, "more items in flight than pipeline stages")
    `MVT_ASSERT(a_ready_when_drained, !out_valid |-> in_ready, "input stalled with empty output")
    `MVT_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "result shown during reset")

endmodule

bind matrix_vector_transform_4x4 mvt_checker u_mvt_checker (.*);
